/* hw/rtl/plt_pkg.sv */
// ----------------------------------------------------------------------------
// plt_pkg
// Types, codes and helpers of the peer link liveness table.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam logic [1:0] OP_RX   = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_SEND = 2'd2;

  localparam logic [3:0] PKT_DISC = 4'd0;
  localparam logic [3:0] PKT_INFO = 4'd1;
  localparam logic [3:0] PKT_HB   = 4'd2;
  localparam logic [3:0] PKT_ACK  = 4'd3;
  localparam logic [3:0] PKT_ERR  = 4'd4;
  localparam logic [3:0] PKT_CMD  = 4'd5;
  localparam logic [3:0] PKT_RES  = 4'd6;
  localparam logic [3:0] PKT_DATA = 4'd7;

  localparam logic [3:0] K_ACK    = 4'd0;
  localparam logic [3:0] K_INFO   = 4'd1;
  localparam logic [3:0] K_CMD    = 4'd2;
  localparam logic [3:0] K_RESULT = 4'd3;
  localparam logic [3:0] K_DATA   = 4'd4;
  localparam logic [3:0] K_FULL   = 4'd5;
  localparam logic [3:0] K_SENT   = 4'd6;
  localparam logic [3:0] K_REJECT = 4'd7;
  localparam logic [3:0] K_DISC   = 4'd8;
  localparam logic [3:0] K_HB     = 4'd9;
  localparam logic [3:0] K_RETX   = 4'd10;
  localparam logic [3:0] K_EXH    = 4'd11;

  localparam logic [2:0] ST_UNKNOWN    = 3'd0;
  localparam logic [2:0] ST_DISCOVERED = 3'd1;
  localparam logic [2:0] ST_ONLINE     = 3'd2;
  localparam logic [2:0] ST_STALE      = 3'd3;
  localparam logic [2:0] ST_OFFLINE    = 3'd4;
  localparam logic [2:0] ST_ERROR      = 3'd5;

  localparam logic [2:0] REG_STALE   = 3'd0;
  localparam logic [2:0] REG_OFFLINE = 3'd1;
  localparam logic [2:0] REG_ACK     = 3'd2;
  localparam logic [2:0] REG_RETRIES = 3'd3;
  localparam logic [2:0] REG_DISC    = 3'd4;
  localparam logic [2:0] REG_HB      = 3'd5;
  localparam logic [2:0] REG_LOCAL   = 3'd6;

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [47:0] mac;
    logic [63:0] id;
    logic [2:0]  state;
    logic [31:0] last_seen;
    logic [15:0] tx_seq;
    logic [15:0] pend_seq;
    logic        pend_valid;
    logic [7:0]  retries;
    logic [31:0] last_tx;
  } rec_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  slot;
    logic [47:0] mac;
    logic [15:0] seq;
    logic [2:0]  state;
    logic        last;
  } res_t;

  function automatic logic [15:0] seq_inc(input logic [15:0] s);
    logic [15:0] t;
    t = s + 16'd1;
    if (t == 16'd0) t = 16'd1;
    return t;
  endfunction

endpackage

/* hw/rtl/plt_ram.sv */
// ----------------------------------------------------------------------------
// plt_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module plt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/peer_link_liveness_table.sv */
// ----------------------------------------------------------------------------
// peer_link_liveness_table
// Peer table keyed by MAC: liveness aging, ack/retry tracking, sequence numbers.
// ----------------------------------------------------------------------------
// Flow: rx and send items walk the table entry by entry (S_RD, S_EV) until a MAC
// match or the last entry; tick items check discovery and heartbeat (S_DISC,
// S_HB), then walk every entry; output stalls can hold any step.
// Throughput: one item at a time; in_ready is high only while the table is idle.
// Reset: control, config and valid bits clear; entry RAM is not swept.
module peer_link_liveness_table #(
  parameter int MAX_PEERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [47:0] in_peer_mac,
  input  logic [31:0] in_now_ms,
  input  logic [3:0]  in_pkt_type,
  input  logic [15:0] in_rx_seq,
  input  logic [15:0] in_rx_ack_seq,
  input  logic        in_need_ack,
  input  logic [63:0] in_payload_id,
  input  logic        in_has_payload_id,
  input  logic        in_cmd_is_result,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_kind,
  output logic [3:0]  out_slot,
  output logic [47:0] out_mac,
  output logic [15:0] out_seq,
  output logic [2:0]  out_peer_state,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PEERS - 1);
  localparam int RW = $bits(plt_pkg::rec_t);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISC  = 3'd1;
  localparam logic [2:0] S_HB    = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_EV    = 3'd4;
  localparam logic [2:0] S_ACT   = 3'd5;
  localparam logic [2:0] S_RX2   = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  logic [31:0] stale_to_r, offline_to_r, ack_to_r, disc_int_r, hb_int_r;
  logic [7:0]  max_retries_r;
  logic [63:0] local_id_r;

  logic [2:0]  state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt, hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic        hit_r, hit_nxt, free_r, free_nxt;
  logic [MAX_PEERS-1:0] active_r, active_nxt;
  plt_pkg::rec_t rec_r, rec_nxt, ram_rdata, ram_wdata, r, c;
  logic [15:0] bseq_r, bseq_nxt;
  logic [31:0] ldisc_r, ldisc_nxt, lhb_r, lhb_nxt;

  logic [1:0]  op_r;
  logic [47:0] mac_r;
  logic [31:0] now_r;
  logic [3:0]  type_r;
  logic [15:0] rseq_r, aseq_r;
  logic        ack_r, has_pid_r;
  logic [63:0] pid_r;

  plt_pkg::res_t held_r, out_r, em_res;
  logic        held_v_r, out_valid_r;
  logic        em, we, ram_we, stall, out_free, loc;
  logic [IW-1:0] waddr, slot_i;
  logic [31:0] silent, since_tx;
  logic [RW-1:0] ram_rd_bits;

  assign out_free = !out_valid_r || out_ready;
  assign stall    = em && held_v_r && !out_free;
  assign ram_we   = we && !stall;
  assign in_ready = (state_r == S_IDLE);
  assign ram_rdata = plt_pkg::rec_t'(ram_rd_bits);

  plt_ram #(.WIDTH(RW), .DEPTH(MAX_PEERS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rd_bits)
  );

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    active_nxt   = active_r;
    rec_nxt      = rec_r;
    bseq_nxt     = bseq_r;
    ldisc_nxt    = ldisc_r;
    lhb_nxt      = lhb_r;
    we           = 1'b0;
    waddr        = idx_r;
    ram_wdata    = rec_r;
    em           = 1'b0;
    em_res       = '0;
    r            = ram_rdata;
    c            = '0;
    slot_i       = hit_r ? hit_idx_r : free_idx_r;
    silent       = now_r - ram_rdata.last_seen;
    since_tx     = now_r - ram_rdata.last_tx;
    loc          = 1'b0;
    case (state_r)
      S_IDLE: begin
        idx_nxt  = '0;
        hit_nxt  = 1'b0;
        free_nxt = 1'b0;
        if (in_valid) begin
          case (in_opcode)
            plt_pkg::OP_RX, plt_pkg::OP_SEND: state_nxt = S_RD;
            plt_pkg::OP_TICK: state_nxt = S_DISC;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DISC: begin
        if (disc_int_r != 32'd0 && (now_r - ldisc_r) >= disc_int_r) begin
          em = 1'b1;
          em_res.kind = plt_pkg::K_DISC;
          em_res.mac  = plt_pkg::MAC_BCAST;
          em_res.seq  = bseq_r;
          bseq_nxt    = plt_pkg::seq_inc(bseq_r);
          ldisc_nxt   = now_r;
        end
        state_nxt = S_HB;
      end
      S_HB: begin
        if (hb_int_r != 32'd0 && (now_r - lhb_r) >= hb_int_r) begin
          em = 1'b1;
          em_res.kind = plt_pkg::K_HB;
          em_res.mac  = plt_pkg::MAC_BCAST;
          em_res.seq  = bseq_r;
          bseq_nxt    = plt_pkg::seq_inc(bseq_r);
          lhb_nxt     = now_r;
        end
        state_nxt = S_RD;
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        if (op_r == plt_pkg::OP_TICK) begin
          if (active_r[idx_r]) begin
            if (silent >= offline_to_r) r.state = plt_pkg::ST_OFFLINE;
            else if (silent >= stale_to_r && r.state == plt_pkg::ST_ONLINE)
              r.state = plt_pkg::ST_STALE;
            if (r.pend_valid && since_tx >= ack_to_r) begin
              em = 1'b1;
              em_res.seq = r.pend_seq;
              if (r.retries >= max_retries_r) begin
                r.pend_valid = 1'b0;
                r.pend_seq   = '0;
                r.retries    = '0;
                r.state      = plt_pkg::ST_ERROR;
                em_res.kind  = plt_pkg::K_EXH;
              end else begin
                r.retries   = r.retries + 8'd1;
                r.last_tx   = now_r;
                em_res.kind = plt_pkg::K_RETX;
              end
              em_res.slot  = 4'(idx_r);
              em_res.mac   = r.mac;
              em_res.state = r.state;
            end
            we        = 1'b1;
            ram_wdata = r;
          end
          if (idx_r == LAST_IDX) state_nxt = S_FLUSH;
          else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end
        end else if (active_r[idx_r] && ram_rdata.mac == mac_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = idx_r;
          rec_nxt     = ram_rdata;
          state_nxt   = S_ACT;
        end else begin
          if (!active_r[idx_r] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = idx_r;
          end
          if (idx_r == LAST_IDX) state_nxt = S_ACT;
          else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_ACT: begin
        state_nxt  = S_FLUSH;
        em_res.mac = mac_r;
        waddr      = slot_i;
        if (op_r == plt_pkg::OP_SEND) begin
          em = 1'b1;
          em_res.kind = plt_pkg::K_REJECT;
          if (hit_r) begin
            em_res.slot  = 4'(hit_idx_r);
            em_res.state = rec_r.state;
            if (rec_r.state != plt_pkg::ST_OFFLINE && rec_r.state != plt_pkg::ST_ERROR) begin
              c = rec_r;
              c.tx_seq = plt_pkg::seq_inc(rec_r.tx_seq);
              if (ack_r) begin
                c.pend_seq   = rec_r.tx_seq;
                c.pend_valid = 1'b1;
                c.retries    = '0;
                c.last_tx    = now_r;
              end
              em_res.kind = plt_pkg::K_SENT;
              em_res.seq  = rec_r.tx_seq;
              we          = 1'b1;
              ram_wdata   = c;
            end
          end
        end else if (!hit_r && !free_r) begin
          em = 1'b1;
          em_res.kind = plt_pkg::K_FULL;
          em_res.seq  = rseq_r;
        end else begin
          if (hit_r) c = rec_r;
          else begin
            c.mac    = mac_r;
            c.state  = plt_pkg::ST_DISCOVERED;
            c.tx_seq = 16'd1;
          end
          c.last_seen = now_r;
          if (c.state == plt_pkg::ST_UNKNOWN || c.state == plt_pkg::ST_OFFLINE)
            c.state = plt_pkg::ST_DISCOVERED;
          if (ack_r) begin
            em = 1'b1;
            em_res.kind  = plt_pkg::K_ACK;
            em_res.slot  = 4'(slot_i);
            em_res.seq   = c.tx_seq;
            em_res.state = c.state;
            c.tx_seq     = plt_pkg::seq_inc(c.tx_seq);
          end
          rec_nxt            = c;
          hit_nxt            = 1'b1;
          hit_idx_nxt        = slot_i;
          active_nxt[slot_i] = 1'b1;
          state_nxt          = S_RX2;
        end
      end
      S_RX2: begin
        c = rec_r;
        if ((type_r == plt_pkg::PKT_DISC || type_r == plt_pkg::PKT_INFO) && has_pid_r)
          c.id = pid_r;
        loc = (c.id != 64'd0) && (local_id_r != 64'd0) && (c.id == local_id_r);
        em_res.slot = 4'(hit_idx_r);
        em_res.mac  = mac_r;
        em_res.seq  = rseq_r;
        case (type_r)
          plt_pkg::PKT_DISC, plt_pkg::PKT_INFO: begin
            if (loc) c.state = plt_pkg::ST_ERROR;
            else if (type_r == plt_pkg::PKT_DISC) begin
              c.state     = plt_pkg::ST_DISCOVERED;
              em          = 1'b1;
              em_res.kind = plt_pkg::K_INFO;
              em_res.seq  = c.tx_seq;
              c.tx_seq    = plt_pkg::seq_inc(c.tx_seq);
            end else c.state = plt_pkg::ST_ONLINE;
          end
          plt_pkg::PKT_ACK: begin
            if (c.pend_valid && c.pend_seq == aseq_r) begin
              c.pend_valid = 1'b0;
              c.pend_seq   = '0;
              c.retries    = '0;
            end
            c.state = plt_pkg::ST_ONLINE;
          end
          plt_pkg::PKT_ERR: c.state = plt_pkg::ST_ERROR;
          plt_pkg::PKT_CMD, plt_pkg::PKT_RES, plt_pkg::PKT_DATA: begin
            if (loc) c.state = plt_pkg::ST_ERROR;
            else begin
              c.state = plt_pkg::ST_ONLINE;
              em      = 1'b1;
              case (type_r)
                plt_pkg::PKT_CMD: em_res.kind = plt_pkg::K_CMD;
                plt_pkg::PKT_RES: em_res.kind = plt_pkg::K_RESULT;
                default:          em_res.kind = plt_pkg::K_DATA;
              endcase
            end
          end
          default: c.state = plt_pkg::ST_ONLINE;
        endcase
        em_res.state = c.state;
        we           = 1'b1;
        waddr        = hit_idx_r;
        ram_wdata    = c;
        state_nxt    = S_FLUSH;
      end
      S_FLUSH: begin
        if (!held_v_r || out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      idx_r         <= '0;
      hit_r         <= 1'b0;
      hit_idx_r     <= '0;
      free_r        <= 1'b0;
      free_idx_r    <= '0;
      active_r      <= '0;
      bseq_r        <= 16'd1;
      ldisc_r       <= '0;
      lhb_r         <= '0;
      held_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      stale_to_r    <= '0;
      offline_to_r  <= '0;
      ack_to_r      <= '0;
      max_retries_r <= '0;
      disc_int_r    <= '0;
      hb_int_r      <= '0;
      local_id_r    <= '0;
    end else begin
      if (state_r == S_FLUSH && held_v_r && out_free) out_valid_r <= 1'b1;
      else if (em && !stall && held_v_r) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (!stall) begin
        state_r    <= state_nxt;
        idx_r      <= idx_nxt;
        hit_r      <= hit_nxt;
        hit_idx_r  <= hit_idx_nxt;
        free_r     <= free_nxt;
        free_idx_r <= free_idx_nxt;
        active_r   <= active_nxt;
        bseq_r     <= bseq_nxt;
        ldisc_r    <= ldisc_nxt;
        lhb_r      <= lhb_nxt;
        if (em) held_v_r <= 1'b1;
      end
      if (state_r == S_FLUSH && held_v_r && out_free) held_v_r <= 1'b0;
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr[5:3])
          plt_pkg::REG_STALE:   stale_to_r    <= cfg_pwdata[31:0];
          plt_pkg::REG_OFFLINE: offline_to_r  <= cfg_pwdata[31:0];
          plt_pkg::REG_ACK:     ack_to_r      <= cfg_pwdata[31:0];
          plt_pkg::REG_RETRIES: max_retries_r <= cfg_pwdata[7:0];
          plt_pkg::REG_DISC:    disc_int_r    <= cfg_pwdata[31:0];
          plt_pkg::REG_HB:      hb_int_r      <= cfg_pwdata[31:0];
          plt_pkg::REG_LOCAL:   local_id_r    <= cfg_pwdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r      <= in_opcode;
      mac_r     <= in_peer_mac;
      now_r     <= in_now_ms;
      type_r    <= in_pkt_type;
      rseq_r    <= in_rx_seq;
      aseq_r    <= in_rx_ack_seq;
      ack_r     <= in_need_ack;
      pid_r     <= in_payload_id;
      has_pid_r <= in_has_payload_id;
    end
    if (!stall) rec_r <= rec_nxt;
    if (em && !stall) begin
      held_r <= em_res;
      if (held_v_r) out_r <= held_r;
    end
    if (state_r == S_FLUSH && held_v_r && out_free)
      out_r <= plt_pkg::res_t'({held_r[$bits(plt_pkg::res_t)-1:1], 1'b1});
  end

  always_comb begin
    case (cfg_paddr[5:3])
      plt_pkg::REG_STALE:   cfg_prdata = {32'd0, stale_to_r};
      plt_pkg::REG_OFFLINE: cfg_prdata = {32'd0, offline_to_r};
      plt_pkg::REG_ACK:     cfg_prdata = {32'd0, ack_to_r};
      plt_pkg::REG_RETRIES: cfg_prdata = {56'd0, max_retries_r};
      plt_pkg::REG_DISC:    cfg_prdata = {32'd0, disc_int_r};
      plt_pkg::REG_HB:      cfg_prdata = {32'd0, hb_int_r};
      plt_pkg::REG_LOCAL:   cfg_prdata = local_id_r;
      default:              cfg_prdata = '0;
    endcase
  end

  assign cfg_pready     = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_kind       = out_r.kind;
  assign out_slot       = out_r.slot;
  assign out_mac        = out_r.mac;
  assign out_seq        = out_r.seq;
  assign out_peer_state = out_r.state;
  assign out_last       = out_r.last;

  a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !held_v_r) else $error("held item left at idle");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_EV || state_r == S_ACT || state_r == S_RX2))
    else $error("table write outside update states");

  a_rx2_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RX2) |-> active_r[hit_idx_r]) else $error("update of inactive entry");

  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == plt_pkg::OP_TICK) |=> (state_r == S_DISC))
    else $error("tick did not start with broadcasts");

endmodule
